// ----- rtl/core/arf_pkg.sv -----
`default_nettype none

package arf_pkg;

    localparam int CMD_W   = 2;
    localparam int RX_W    = 6;
    localparam int IDX_W   = 7;
    localparam int DROP_W  = 4;
    localparam int CRED_W  = 6;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_DROP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECV = 2'd1;

    localparam logic [1:0] REG_MIN_RATE   = 2'd0;
    localparam logic [1:0] REG_MAX_RATE   = 2'd1;
    localparam logic [1:0] REG_DROP_THR   = 2'd2;
    localparam logic [1:0] REG_CREDIT_THR = 2'd3;

    localparam logic [IDX_W-1:0]  RST_MIN_RATE   = 7'd1;
    localparam logic [IDX_W-1:0]  RST_MAX_RATE   = 7'd4;
    localparam logic [DROP_W-1:0] RST_DROP_THR   = 4'd3;
    localparam logic [CRED_W-1:0] RST_CREDIT_THR = 6'd19;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DROP_W-1:0] drops;
        logic [CRED_W-1:0] credits;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_stall;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/arf_ram.sv -----
`default_nettype none

module arf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/arf_ctrl.sv -----
`default_nettype none

module arf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire arf_pkg::t_dp_sts i_sts,
    output arf_pkg::t_dp_cmd      o_cmd
);

    arf_pkg::t_state r_state;
    arf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            arf_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = arf_pkg::ST_IDLE;
                end
            end
            arf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = arf_pkg::ST_CALC;
                end
            end
            arf_pkg::ST_CALC: begin
                // hold until the result register is free
                if (!i_sts.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = arf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arf_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/arf_dp.sv -----
`default_nettype none

module arf_dp #(
    parameter int RECEIVERS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire arf_pkg::t_dp_cmd              i_cmd,
    output arf_pkg::t_dp_sts                   o_sts,
    input  wire logic [arf_pkg::CMD_W-1:0]     i_command,
    input  wire logic [arf_pkg::RX_W-1:0]      i_receiver,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [arf_pkg::IDX_W-1:0]     o_rate_index,
    output logic                               o_stepped_down,
    output logic                               o_stepped_up,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [arf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [arf_pkg::PDATA_W-1:0]   pwdata,
    output logic      [arf_pkg::PDATA_W-1:0]   prdata
);

    localparam int AW = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
    localparam int EW = $bits(arf_pkg::t_entry);

    logic [arf_pkg::IDX_W-1:0]  r_min_rate;
    logic [arf_pkg::IDX_W-1:0]  r_max_rate;
    logic [arf_pkg::DROP_W-1:0] r_drop_thr;
    logic [arf_pkg::CRED_W-1:0] r_credit_thr;

    logic [AW-1:0]              r_clr_addr;
    logic [arf_pkg::CMD_W-1:0]  r_cmd;
    logic [AW-1:0]              r_addr;
    logic                       r_in_range;

    logic                       r_out_valid;
    logic [arf_pkg::IDX_W-1:0]  r_rate_index;
    logic                       r_stepped_down;
    logic                       r_stepped_up;

    logic [AW+arf_pkg::RX_W-1:0] rx_ext;
    logic [AW-1:0]               rd_addr;
    logic [EW-1:0]               ram_rdata;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;

    arf_pkg::t_entry             rd_ent;
    arf_pkg::t_entry             nx_ent;
    logic [arf_pkg::IDX_W-1:0]   cur_idx;
    logic [arf_pkg::IDX_W-1:0]   nx_idx;
    logic [arf_pkg::DROP_W:0]    drop_inc;
    logic [arf_pkg::CRED_W:0]    cred_inc;
    logic                        nx_down;
    logic                        nx_up;
    logic                        wr_need;
    logic                        cfg_wr;

    assign rx_ext  = {{AW{1'b0}}, i_receiver};
    assign rd_addr = rx_ext[AW-1:0];

    arf_ram #(
        .WIDTH (EW),
        .DEPTH (RECEIVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate   <= arf_pkg::RST_MIN_RATE;
            r_max_rate   <= arf_pkg::RST_MAX_RATE;
            r_drop_thr   <= arf_pkg::RST_DROP_THR;
            r_credit_thr <= arf_pkg::RST_CREDIT_THR;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                arf_pkg::REG_MIN_RATE:   r_min_rate   <= pwdata[arf_pkg::IDX_W-1:0];
                arf_pkg::REG_MAX_RATE:   r_max_rate   <= pwdata[arf_pkg::IDX_W-1:0];
                arf_pkg::REG_DROP_THR:   r_drop_thr   <= pwdata[arf_pkg::DROP_W-1:0];
                arf_pkg::REG_CREDIT_THR: r_credit_thr <= pwdata[arf_pkg::CRED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            arf_pkg::REG_MIN_RATE:
                prdata = {{(arf_pkg::PDATA_W-arf_pkg::IDX_W){1'b0}}, r_min_rate};
            arf_pkg::REG_MAX_RATE:
                prdata = {{(arf_pkg::PDATA_W-arf_pkg::IDX_W){1'b0}}, r_max_rate};
            arf_pkg::REG_DROP_THR:
                prdata = {{(arf_pkg::PDATA_W-arf_pkg::DROP_W){1'b0}}, r_drop_thr};
            arf_pkg::REG_CREDIT_THR:
                prdata = {{(arf_pkg::PDATA_W-arf_pkg::CRED_W){1'b0}}, r_credit_thr};
            default:
                prdata = '0;
        endcase
    end

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(RECEIVERS - 1));
    assign o_sts.out_stall = r_out_valid && !i_out_ready;

    // capture the transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd      <= i_command;
            r_addr     <= rd_addr;
            r_in_range <= (32'(i_receiver) < RECEIVERS);
        end
    end

    // update of one entry
    always_comb begin
        rd_ent   = arf_pkg::t_entry'(ram_rdata);
        cur_idx  = rd_ent.valid ? rd_ent.idx : r_max_rate;
        drop_inc = {1'b0, rd_ent.drops} + {{arf_pkg::DROP_W{1'b0}}, 1'b1};
        cred_inc = {1'b0, rd_ent.credits} + {{arf_pkg::CRED_W{1'b0}}, 1'b1};
        nx_idx   = cur_idx;
        nx_down  = 1'b0;
        nx_up    = 1'b0;
        nx_ent   = rd_ent;
        wr_need  = 1'b0;
        priority if (!r_in_range) begin
            nx_idx = r_max_rate;
        end else begin
            unique case (r_cmd)
                arf_pkg::CMD_DROP: begin
                    nx_ent.drops   = drop_inc[arf_pkg::DROP_W-1:0];
                    if (drop_inc > {1'b0, r_drop_thr}) begin
                        if (cur_idx > r_min_rate) begin
                            nx_idx  = cur_idx - arf_pkg::IDX_W'(1);
                            nx_down = 1'b1;
                        end
                        nx_ent.drops = '0;
                    end
                    nx_ent.credits = '0;
                    nx_ent.idx     = nx_idx;
                    nx_ent.valid   = 1'b1;
                    wr_need        = 1'b1;
                end
                arf_pkg::CMD_RECV: begin
                    nx_ent.credits = cred_inc[arf_pkg::CRED_W-1:0];
                    if (cred_inc > {1'b0, r_credit_thr}) begin
                        if (cur_idx < r_max_rate) begin
                            nx_idx = cur_idx + arf_pkg::IDX_W'(1);
                            nx_up  = 1'b1;
                        end
                        nx_ent.credits = '0;
                    end
                    nx_ent.drops = '0;
                    nx_ent.idx   = nx_idx;
                    nx_ent.valid = 1'b1;
                    wr_need      = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign ram_we    = i_cmd.clr_wr || (i_cmd.commit && wr_need);
    assign ram_waddr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign ram_wdata = i_cmd.clr_wr ? '0 : EW'(nx_ent);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rate_index   <= nx_idx;
            r_stepped_down <= nx_down;
            r_stepped_up   <= nx_up;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rate_index   = r_rate_index;
    assign o_stepped_down = r_stepped_down;
    assign o_stepped_up   = r_stepped_up;

endmodule

`default_nettype wire

// ----- rtl/core/auto_rate_fallback_per_receiver_unit.sv -----
`default_nettype none

// Per-receiver auto rate fallback. Each input transfer carries a drop, a
// receive or a query for one receiver and returns one result: the receiver's
// rate index after the event and whether it stepped down or up. State for all
// RECEIVERS lives in one RAM entry per receiver (index, valid, drop count,
// success count). Each item first reads the receiver's entry from the RAM
// port, then updates it, writes it back and loads the result register; the
// next item is accepted only after the write-back, so a new item is not taken
// while one is in flight, and the update waits while a result is not taken.
// After reset the RAM is cleared one entry a cycle, so no input is accepted
// until every entry is cleared; register writes are taken during that sweep.
module auto_rate_fallback_per_receiver_unit #(
    parameter int RECEIVERS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [arf_pkg::CMD_W-1:0]     i_command,
    input  wire logic [arf_pkg::RX_W-1:0]      i_receiver,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [arf_pkg::IDX_W-1:0]     o_rate_index,
    output logic                               o_stepped_down,
    output logic                               o_stepped_up,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [arf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [arf_pkg::PDATA_W-1:0]   pwdata,
    output logic      [arf_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    arf_pkg::t_dp_cmd dp_cmd;
    arf_pkg::t_dp_sts dp_sts;

    assign pready = 1'b1;

    arf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    arf_dp #(
        .RECEIVERS (RECEIVERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_command      (i_command),
        .i_receiver     (i_receiver),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_rate_index   (o_rate_index),
        .o_stepped_down (o_stepped_down),
        .o_stepped_up   (o_stepped_up),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/arf_chk.sv -----
`default_nettype none

module arf_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [arf_pkg::IDX_W-1:0]   o_rate_index,
    input wire logic                        o_stepped_down,
    input wire logic                        o_stepped_up
);

    // one step direction per result
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_stepped_down && o_stepped_up))
        else $error("both step flags set");

    // a new result follows an accepted input transfer, after the RAM read and the update
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without matching input transfer");

    // one item in flight at a time
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_rate_index) && $stable(o_stepped_down)
             && $stable(o_stepped_up)))
        else $error("stalled result changed");

endmodule

bind auto_rate_fallback_per_receiver_unit arf_chk u_arf_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_rate_index   (o_rate_index),
    .o_stepped_down (o_stepped_down),
    .o_stepped_up   (o_stepped_up)
);

`default_nettype wire
